[src/gdr_pkg.sv]
package gdr_pkg;

  localparam int DEF_MAP_SIDE  = 64;
  localparam int DEF_MAX_STEPS = 200;

  // Operand widths of the shared divider.
  localparam int DVD_W = 40;
  localparam int DVS_W = 32;

  localparam int TS_W  = 24;
  localparam int CRD_W = 34;
  localparam int TM_W  = 50;
  localparam int H_W   = 48;

  localparam logic [7:0] CH_AMP  = 8'h26;
  localparam logic [7:0] CH_AT   = 8'h40;
  localparam logic [7:0] CH_HASH = 8'h23;

  localparam logic [7:0] CFG_TILE_SIZE   = 8'd0;
  localparam logic [7:0] CFG_WALL_HEIGHT = 8'd1;
  localparam logic [7:0] CFG_MAP_WIDTH   = 8'd2;
  localparam logic [7:0] CFG_MAP_HEIGHT  = 8'd3;

  typedef enum logic [2:0] {
    OP_COL = 3'd0,
    OP_ROW = 3'd1,
    OP_TMX = 3'd2,
    OP_TDX = 3'd3,
    OP_TMZ = 3'd4,
    OP_TDZ = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    MS_NONE = 2'd0,
    MS_X    = 2'd1,
    MS_Y    = 2'd2,
    MS_Z    = 2'd3
  } mul_sel_t;

  typedef struct packed {
    logic     load;
    logic     write_cell;
    logic     clear;
    logic     div_start;
    op_t      op;
    logic     step;
    mul_sel_t mul_sel;
    logic     emit;
    logic     found;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_done;
    logic clear_last;
    logic cell_hit;
    logic can_step;
    logic stop;
  } dp_sts_t;

endpackage

[src/gdr_div.sv]
module gdr_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [gdr_pkg::DVD_W-1:0] dividend,
  input  logic [gdr_pkg::DVS_W-1:0] divisor,
  output logic                      done,
  output logic [gdr_pkg::DVD_W-1:0] quotient,
  output logic [gdr_pkg::DVS_W-1:0] remainder
);
  import gdr_pkg::*;

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] dvd;
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [CNT_W-1:0] cnt;
  logic [DVS_W:0]   sh;
  logic [DVS_W+1:0] diff;
  logic             ge;

  // One quotient bit per cycle; quotient bits shift in behind the dividend.
  always_comb begin
    sh   = {rem, dvd[DVD_W-1]};
    diff = {1'b0, sh} - {2'b00, dvs};
    ge   = !diff[DVS_W+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CNT_W'(DVD_W);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (cnt != '0) begin
      dvd <= {dvd[DVD_W-2:0], ge};
      rem <= ge ? diff[DVS_W-1:0] : sh[DVS_W-1:0];
    end
  end

  assign quotient  = dvd;
  assign remainder = rem;

endmodule

[src/gdr_datapath.sv]
module gdr_datapath #(
  parameter int MAP_SIDE  = gdr_pkg::DEF_MAP_SIDE,
  parameter int MAX_STEPS = gdr_pkg::DEF_MAX_STEPS
) (
  input  logic               clk,
  input  logic               rst,
  input  gdr_pkg::ctrl_cmd_t cmd,
  output gdr_pkg::dp_sts_t   sts,
  input  logic               cfg_valid,
  input  logic [7:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic [11:0]        cell_index,
  input  logic [7:0]         cell_code,
  input  logic signed [31:0] origin_x,
  input  logic signed [31:0] origin_y,
  input  logic signed [31:0] origin_z,
  input  logic signed [31:0] dir_x,
  input  logic signed [31:0] dir_y,
  input  logic signed [31:0] dir_z,
  input  logic [30:0]        max_dist,
  output logic               done,
  output logic               hit,
  output logic signed [31:0] hit_x,
  output logic signed [31:0] hit_y,
  output logic signed [31:0] hit_z,
  output logic signed [1:0]  normal_x,
  output logic signed [1:0]  normal_z
);
  import gdr_pkg::*;

  localparam int CELLS  = MAP_SIDE * MAP_SIDE;
  localparam int AW     = $clog2(CELLS);
  localparam int SIDE_W = $clog2(MAP_SIDE + 1);
  localparam int CNT_W  = $clog2(MAX_STEPS + 1);

  function automatic logic [31:0] sat32(input logic signed [H_W-1:0] v);
    logic [31:0] r;
    if (v > $signed(H_W'(32'h7FFF_FFFF))) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -$signed(H_W'(33'h0_8000_0000))) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic [1:0] neg_sign(input logic signed [31:0] d);
    logic [1:0] r;
    if (d == '0) begin
      r = 2'b00;
    end else if (d[31]) begin
      r = 2'b01;
    end else begin
      r = 2'b11;
    end
    return r;
  endfunction

  // Configuration registers.
  logic [23:0] tile_size;
  logic [30:0] wall_height;
  logic [6:0]  map_width;
  logic [6:0]  map_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      tile_size   <= 24'd65536;
      wall_height <= 31'd65536;
      map_width   <= 7'd64;
      map_height  <= 7'd64;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_TILE_SIZE:   tile_size   <= cfg_data[23:0];
        CFG_WALL_HEIGHT: wall_height <= cfg_data[30:0];
        CFG_MAP_WIDTH:   map_width   <= cfg_data[6:0];
        CFG_MAP_HEIGHT:  map_height  <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  logic [TS_W-1:0]   ts;
  logic [SIDE_W-1:0] w_eff;
  logic [SIDE_W-1:0] h_eff;

  always_comb begin
    ts    = (tile_size == '0) ? TS_W'(1) : tile_size;
    w_eff = (32'(map_width) > MAP_SIDE) ? SIDE_W'(MAP_SIDE) : SIDE_W'(map_width);
    h_eff = (32'(map_height) > MAP_SIDE) ? SIDE_W'(MAP_SIDE) : SIDE_W'(map_height);
  end

  // Latched cast operands.
  logic signed [31:0] ox, oy, oz, dx, dy, dz;
  logic [30:0]        maxd;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ox   <= origin_x;
      oy   <= origin_y;
      oz   <= origin_z;
      dx   <= dir_x;
      dy   <= dir_y;
      dz   <= dir_z;
      maxd <= max_dist;
    end
  end

  logic fx, fz;
  logic [31:0] abs_ox, abs_oz, abs_dx, abs_dz;

  always_comb begin
    fx     = (dx != '0);
    fz     = (dz != '0);
    abs_ox = ox[31] ? 32'(-ox) : 32'(ox);
    abs_oz = oz[31] ? 32'(-oz) : 32'(oz);
    abs_dx = dx[31] ? 32'(-dx) : 32'(dx);
    abs_dz = dz[31] ? 32'(-dz) : 32'(dz);
  end

  // Grid walk state.
  logic signed [CRD_W-1:0] col, row;
  logic [TS_W-1:0]         rx, rz;
  logic [TM_W-1:0]         tmx, tmz, tdx, tdz, t;
  logic [CNT_W-1:0]        cnt;
  logic                    stepped_x;

  // Divider operand selection.
  logic [DVD_W-1:0] div_dvd;
  logic [DVS_W-1:0] div_dvs;
  logic [DVD_W-1:0] quot;
  logic [DVS_W-1:0] rem;
  logic             div_done;
  logic [TS_W-1:0]  numx_mag, numz_mag;

  always_comb begin
    numx_mag = dx[31] ? rx : ts - rx;
    numz_mag = dz[31] ? rz : ts - rz;
    div_dvd  = DVD_W'(abs_ox);
    div_dvs  = DVS_W'(ts);
    case (cmd.op)
      OP_COL: begin
        div_dvd = DVD_W'(abs_ox);
        div_dvs = DVS_W'(ts);
      end
      OP_ROW: begin
        div_dvd = DVD_W'(abs_oz);
        div_dvs = DVS_W'(ts);
      end
      OP_TMX: begin
        div_dvd = DVD_W'({numx_mag, 16'h0000});
        div_dvs = abs_dx;
      end
      OP_TDX: begin
        div_dvd = DVD_W'({ts, 16'h0000});
        div_dvs = abs_dx;
      end
      OP_TMZ: begin
        div_dvd = DVD_W'({numz_mag, 16'h0000});
        div_dvs = abs_dz;
      end
      OP_TDZ: begin
        div_dvd = DVD_W'({ts, 16'h0000});
        div_dvs = abs_dz;
      end
      default: ;
    endcase
  end

  gdr_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (div_dvd),
    .divisor   (div_dvs),
    .done      (div_done),
    .quotient  (quot),
    .remainder (rem)
  );

  // Floor division result: negative origins round towards minus infinity.
  logic [CRD_W-1:0] q_mag;
  logic             rem_nz;
  logic [TS_W-1:0]  rem_ts;
  logic             step_x;

  always_comb begin
    q_mag  = CRD_W'(quot[32:0]);
    rem_nz = (rem != '0);
    rem_ts = rem[TS_W-1:0];
    step_x = fx && (!fz || (tmx < tmz));
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      t         <= '0;
      cnt       <= '0;
      stepped_x <= 1'b0;
    end else if (cmd.step) begin
      cnt <= cnt + 1'b1;
      if (step_x) begin
        t         <= tmx;
        tmx       <= tmx + tdx;
        col       <= dx[31] ? col - 1'b1 : col + 1'b1;
        stepped_x <= 1'b1;
      end else begin
        t         <= tmz;
        tmz       <= tmz + tdz;
        row       <= dz[31] ? row - 1'b1 : row + 1'b1;
        stepped_x <= 1'b0;
      end
    end else if (div_done) begin
      case (cmd.op)
        OP_COL: begin
          col <= ox[31] ? $signed(-q_mag - CRD_W'(rem_nz)) : $signed(q_mag);
          rx  <= (ox[31] && rem_nz) ? ts - rem_ts : (ox[31] ? '0 : rem_ts);
        end
        OP_ROW: begin
          row <= oz[31] ? $signed(-q_mag - CRD_W'(rem_nz)) : $signed(q_mag);
          rz  <= (oz[31] && rem_nz) ? ts - rem_ts : (oz[31] ? '0 : rem_ts);
        end
        OP_TMX: tmx <= TM_W'(quot);
        OP_TDX: tdx <= TM_W'(quot);
        OP_TMZ: tmz <= TM_W'(quot);
        OP_TDZ: tdz <= TM_W'(quot);
        default: ;
      endcase
    end
  end

  // Tile map with a registered read port and a sweep that clears it after reset.
  logic             mem [0:CELLS-1];
  logic [AW-1:0]    clr_addr;
  logic [AW-1:0]    raddr;
  logic             rd_data;
  logic             in_range;
  logic             code_solid;
  logic             widx_ok;

  always_comb begin
    in_range = !col[CRD_W-1] && !row[CRD_W-1] &&
               (col < CRD_W'(w_eff)) && (row < CRD_W'(h_eff));
    raddr = AW'(32'(row[SIDE_W-1:0]) * 32'(w_eff) + 32'(col[SIDE_W-1:0]));
    code_solid = (cell_code == CH_AMP) || (cell_code == CH_AT) || (cell_code == CH_HASH);
    widx_ok = (32'(cell_index) < CELLS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      mem[clr_addr] <= 1'b0;
    end else if (cmd.write_cell && widx_ok) begin
      mem[AW'(cell_index)] <= code_solid;
    end
    rd_data <= mem[raddr];
  end

  // Hit point: one multiplier shared by the three axes.
  logic signed [31:0]    mul_a;
  logic signed [31:0]    mul_b;
  logic signed [63:0]    prod;
  logic signed [31:0]    acc_o;
  logic signed [H_W-1:0] hval;
  logic signed [H_W-1:0] hx, hy, hz;
  mul_sel_t              mul_prev;
  logic                  hy_ok;

  always_comb begin
    mul_b = $signed({1'b0, t[30:0]});
    case (cmd.mul_sel)
      MS_X:    mul_a = dx;
      MS_Y:    mul_a = dy;
      MS_Z:    mul_a = dz;
      default: mul_a = dx;
    endcase
    case (mul_prev)
      MS_X:    acc_o = ox;
      MS_Y:    acc_o = oy;
      MS_Z:    acc_o = oz;
      default: acc_o = ox;
    endcase
    hval  = H_W'(acc_o) + H_W'(prod >>> 16);
    hy_ok = !hy[H_W-1] && (hy <= $signed(H_W'(wall_height)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_prev <= MS_NONE;
    end else begin
      mul_prev <= cmd.mul_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_sel != MS_NONE) begin
      prod <= mul_a * mul_b;
    end
    case (mul_prev)
      MS_X:    hx <= hval;
      MS_Y:    hy <= hval;
      MS_Z:    hz <= hval;
      default: ;
    endcase
  end

  // Result word.
  logic res_hit;

  always_comb begin
    res_hit = cmd.found && hy_ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      hit      <= res_hit;
      hit_x    <= res_hit ? sat32(hx) : '0;
      hit_y    <= res_hit ? sat32(hy) : '0;
      hit_z    <= res_hit ? sat32(hz) : '0;
      normal_x <= (res_hit && stepped_x) ? neg_sign(dx) : 2'b00;
      normal_z <= (res_hit && !stepped_x) ? neg_sign(dz) : 2'b00;
    end
  end

  always_comb begin
    sts.div_done   = div_done;
    sts.clear_last = (clr_addr == AW'(CELLS - 1));
    sts.cell_hit   = in_range && rd_data;
    sts.can_step   = fx || fz;
    sts.stop       = (t > TM_W'(maxd)) || (cnt == CNT_W'(MAX_STEPS));
  end

endmodule

[src/gdr_ctrl.sv]
module gdr_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               cast,
  input  gdr_pkg::dp_sts_t   sts,
  output gdr_pkg::ctrl_cmd_t cmd,
  output logic               busy
);
  import gdr_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE     = 11'b000_0000_0001,
    S_CLEAR    = 11'b000_0000_0010,
    S_DIV_GO   = 11'b000_0000_0100,
    S_DIV_WAIT = 11'b000_0000_1000,
    S_LOOK     = 11'b000_0001_0000,
    S_TEST     = 11'b000_0010_0000,
    S_MULX     = 11'b000_0100_0000,
    S_MULY     = 11'b000_1000_0000,
    S_MULZ     = 11'b001_0000_0000,
    S_MULW     = 11'b010_0000_0000,
    S_FINISH   = 11'b100_0000_0000
  } state_t;

  state_t state, state_next;
  op_t    op, op_next;
  logic   found, found_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      op    <= OP_COL;
      found <= 1'b0;
    end else begin
      state <= state_next;
      op    <= op_next;
      found <= found_next;
    end
  end

  always_comb begin
    state_next     = state;
    op_next        = op;
    found_next     = found;
    cmd            = '0;
    cmd.op         = op;
    cmd.mul_sel    = MS_NONE;
    cmd.found      = found;
    case (state)
      S_IDLE: begin
        if (start) begin
          if (cast) begin
            cmd.load   = 1'b1;
            op_next    = OP_COL;
            found_next = 1'b0;
            state_next = S_DIV_GO;
          end else begin
            cmd.write_cell = 1'b1;
          end
        end
      end
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (sts.div_done) begin
          state_next = S_DIV_GO;
          case (op)
            OP_COL:  op_next = OP_ROW;
            OP_ROW:  op_next = OP_TMX;
            OP_TMX:  op_next = OP_TDX;
            OP_TDX:  op_next = OP_TMZ;
            OP_TMZ:  op_next = OP_TDZ;
            default: state_next = S_LOOK;
          endcase
        end
      end
      S_LOOK: begin
        // The map word for the current cell is read during this cycle.
        state_next = sts.stop ? S_FINISH : S_TEST;
      end
      S_TEST: begin
        if (sts.cell_hit) begin
          found_next = 1'b1;
          state_next = S_MULX;
        end else if (sts.can_step) begin
          cmd.step   = 1'b1;
          state_next = S_LOOK;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_MULX: begin
        cmd.mul_sel = MS_X;
        state_next  = S_MULY;
      end
      S_MULY: begin
        cmd.mul_sel = MS_Y;
        state_next  = S_MULZ;
      end
      S_MULZ: begin
        cmd.mul_sel = MS_Z;
        state_next  = S_MULW;
      end
      S_MULW: begin
        state_next = S_FINISH;
      end
      S_FINISH: begin
        cmd.emit   = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

[src/grid_dda_wall_raycast_core.sv]
// Tile map ray caster over the X-Z grid.
// Items arrive on start with cmd selecting the kind; an item is taken at a
// clock edge where start is high and busy is low. A map write (cmd 0) is
// stored at that edge and produces no result; the next item may follow in
// the very next cycle. A cast (cmd 1) raises busy and produces exactly one
// result word, shown for one cycle with done high; the receiver must take
// it then, as there is no way to hold it off.
// A cast makes six passes through one shared radix-2 divider, then goes
// through the LOOK and TEST states for each grid step, bounded by the
// map read of each step, then through the MULX, MULY, MULZ, MULW and
// FINISH states for the hit point and the result.
// Configuration writes use cfg_valid and cfg_index with cfg_data; cfg_ready
// is always high. Writes are meant for idle periods only.
// After reset the map is swept to all open, one cell a cycle, over all
// MAP_SIDE * MAP_SIDE cells (4096 by default) with busy high.
module grid_dda_wall_raycast_core #(
  parameter int MAP_SIDE  = gdr_pkg::DEF_MAP_SIDE,
  parameter int MAX_STEPS = gdr_pkg::DEF_MAX_STEPS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               cmd,
  input  logic [11:0]        cell_index,
  input  logic [7:0]         cell_code,
  input  logic signed [31:0] origin_x,
  input  logic signed [31:0] origin_y,
  input  logic signed [31:0] origin_z,
  input  logic signed [31:0] dir_x,
  input  logic signed [31:0] dir_y,
  input  logic signed [31:0] dir_z,
  input  logic [30:0]        max_dist,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output logic               done,
  output logic               hit,
  output logic signed [31:0] hit_x,
  output logic signed [31:0] hit_y,
  output logic signed [31:0] hit_z,
  output logic signed [1:0]  normal_x,
  output logic signed [1:0]  normal_z
);
  import gdr_pkg::*;

  ctrl_cmd_t ctl_cmd;
  dp_sts_t   ctl_sts;

  assign cfg_ready = 1'b1;

  gdr_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cast  (cmd),
    .sts   (ctl_sts),
    .cmd   (ctl_cmd),
    .busy  (busy)
  );

  gdr_datapath #(
    .MAP_SIDE  (MAP_SIDE),
    .MAX_STEPS (MAX_STEPS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (ctl_cmd),
    .sts        (ctl_sts),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cell_index (cell_index),
    .cell_code  (cell_code),
    .origin_x   (origin_x),
    .origin_y   (origin_y),
    .origin_z   (origin_z),
    .dir_x      (dir_x),
    .dir_y      (dir_y),
    .dir_z      (dir_z),
    .max_dist   (max_dist),
    .done       (done),
    .hit        (hit),
    .hit_x      (hit_x),
    .hit_y      (hit_y),
    .hit_z      (hit_z),
    .normal_x   (normal_x),
    .normal_z   (normal_z)
  );

`ifndef SYNTHESIS
  a_cast_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && cmd) |=> busy)
    else $error("cast taken but block not busy");

  a_write_no_word: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !cmd) |=> !done)
    else $error("map write produced a result word");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result word without a cast in progress");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result word repeated");
`endif

endmodule
